/* rtl/core/bds_pkg.sv */
package bds_pkg;

  localparam int NUM_LANES    = 4;
  localparam int LANE_W       = 8;
  localparam int SUM_W        = LANE_W + 1;
  localparam int ENTRY_W      = NUM_LANES * SUM_W;
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int SLOT_W       = $clog2(LINE_DEPTH);
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int WIDTH_W      = COL_W + 1;
  localparam int HEIGHT_W     = ROW_W + 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = HEIGHT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOUR_BYTE_PIXELS = 2'd2;

  typedef logic [LANE_W-1:0] px_byte_t;

  // Stage-one control handed to the output merge
  typedef struct packed {
    logic vld;
    logic last;
  } s1_ctl_t;

endpackage

/* rtl/core/bds_lane.sv */
module bds_lane
  import bds_pkg::*;
(
  input  logic             clk,
  input  px_byte_t         first_byte,
  input  px_byte_t         cur_byte,
  input  logic             load,
  input  logic [SUM_W-1:0] stored_sum,
  output logic [SUM_W-1:0] pair_sum,
  output px_byte_t         avg_byte
);

  logic [SUM_W-1:0] pair_r;
  logic [SUM_W:0]   quad_sum;

  assign pair_sum = {1'b0, first_byte} + {1'b0, cur_byte};

  // hold the pair sum of the odd row until the stored one arrives
  always_ff @(posedge clk) begin
    if (load) begin
      pair_r <= pair_sum;
    end
  end

  assign quad_sum = {1'b0, stored_sum} + {1'b0, pair_r};
  assign avg_byte = quad_sum[SUM_W:2];

endmodule

/* rtl/core/bds_merge.sv */
module bds_merge
  import bds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  s1_ctl_t  s1_ctl,
  input  logic     four_byte,
  input  px_byte_t lane_avg [NUM_LANES],
  output logic     s1_go,
  input  logic     out_ready,
  output logic     out_valid,
  output px_byte_t out_avg_byte0,
  output px_byte_t out_avg_byte1,
  output px_byte_t out_avg_byte2,
  output px_byte_t out_avg_byte3,
  output logic     out_last_pixel
);

  logic     out_valid_r;
  logic     out_valid_nxt;
  px_byte_t avg_r [NUM_LANES];
  logic     last_r;

  assign s1_go         = s1_ctl.vld && (!out_valid_r || out_ready);
  assign out_valid_nxt = s1_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      avg_r[0] <= lane_avg[0];
      avg_r[1] <= lane_avg[1];
      avg_r[2] <= lane_avg[2];
      avg_r[3] <= four_byte ? lane_avg[3] : '0;
      last_r   <= s1_ctl.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_avg_byte0  = avg_r[0];
  assign out_avg_byte1  = avg_r[1];
  assign out_avg_byte2  = avg_r[2];
  assign out_avg_byte3  = avg_r[3];
  assign out_last_pixel = last_r;

endmodule

/* rtl/core/box_downsample_2x2_unit.sv */
// 2x2 box downsampler: takes one source pixel per clock in raster order and
// returns one half-resolution pixel per 2x2 block, each byte being the sum of
// the four matching source bytes shifted right by two (truncating). A new
// pixel is taken every cycle; the only stall comes from out_ready, through a
// one-deep stage in front of the output register. Accepting the second
// pixel of an odd-row pair loads that stage from the registered line store
// read; the final add is done there, then the output register takes it. Four
// byte lanes form the horizontal pair sums; on even rows the packed pair sums
// go into a 512-entry line store, on odd rows they are added to what the even
// row left there. last_pixel marks the final output of an image. Write the
// geometry registers only while idle; a write to a known index restarts the
// image at row 0, column 0. If width or height is odd, below 2 or above its
// limit, pixels are accepted and no output is produced. There is no clearing
// pass after reset: the line store is always written before it is read.
module box_downsample_2x2_unit
  import bds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // source pixel transactions
  input  logic                  in_valid,
  output logic                  in_ready,
  input  px_byte_t              in_byte0,
  input  px_byte_t              in_byte1,
  input  px_byte_t              in_byte2,
  input  px_byte_t              in_byte3,
  // averaged pixel transactions
  output logic                  out_valid,
  input  logic                  out_ready,
  output px_byte_t              out_avg_byte0,
  output px_byte_t              out_avg_byte1,
  output px_byte_t              out_avg_byte2,
  output px_byte_t              out_avg_byte3,
  output logic                  out_last_pixel,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [WIDTH_W-1:0]  src_width_r;
  logic [HEIGHT_W-1:0] src_height_r;
  logic                four_byte_r;
  logic                cfg_we;

  // position counters
  logic [COL_W-1:0]    col_cnt_r;
  logic [COL_W-1:0]    col_cnt_nxt;
  logic [ROW_W-1:0]    row_cnt_r;
  logic [ROW_W-1:0]    row_cnt_nxt;

  logic                geom_ok;
  logic                in_acc;
  logic                active;
  logic                col_last;
  logic                row_last;
  logic                wr_en;
  logic                rd_en;
  logic [SLOT_W-1:0]   slot;

  px_byte_t            cur_byte [NUM_LANES];
  px_byte_t            first_r  [NUM_LANES];
  logic [SUM_W-1:0]    pair_sum [NUM_LANES];
  px_byte_t            lane_avg [NUM_LANES];
  logic [ENTRY_W-1:0]  wr_data;

  logic [ENTRY_W-1:0]  line_mem [LINE_DEPTH];
  logic [ENTRY_W-1:0]  rd_data_r;

  s1_ctl_t             s1_ctl_r;
  s1_ctl_t             s1_ctl_nxt;
  logic                s1_go;

  // Configuration: always ready; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready &&
                     (cfg_index inside {REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT,
                                        REG_FOUR_BYTE_PIXELS});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= WIDTH_W'(2);
      src_height_r <= HEIGHT_W'(2);
      four_byte_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:     src_width_r  <= cfg_data[WIDTH_W-1:0];
        REG_SOURCE_HEIGHT:    src_height_r <= cfg_data;
        REG_FOUR_BYTE_PIXELS: four_byte_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Geometry must be even, at least 2 and within the line store / row range.
  assign geom_ok = (src_width_r >= WIDTH_W'(2)) && !src_width_r[0] &&
                   (src_width_r <= WIDTH_W'(MAX_WIDTH)) &&
                   (src_height_r >= HEIGHT_W'(2)) && !src_height_r[0] &&
                   (src_height_r <= HEIGHT_W'(HEIGHT_LIMIT));

  // Accept whenever stage one is empty or will advance this cycle.
  assign in_ready = !s1_ctl_r.vld || s1_go;
  assign in_acc   = in_valid && in_ready;
  assign active   = in_acc && geom_ok;

  assign col_last = ({1'b0, col_cnt_r} + WIDTH_W'(1)) == src_width_r;
  assign row_last = ({1'b0, row_cnt_r} + HEIGHT_W'(1)) == src_height_r;
  assign slot     = col_cnt_r[COL_W-1:1];

  // Second pixel of a pair: even rows store, odd rows fetch and emit.
  assign wr_en = active && col_cnt_r[0] && !row_cnt_r[0];
  assign rd_en = active && col_cnt_r[0] && row_cnt_r[0];

  // Advance the raster position; wrap at row and image end, reset on a write.
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cfg_we) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (active) begin
      if (col_last) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_last ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Fourth byte reads as zero in three-byte mode.
  assign cur_byte[0] = in_byte0;
  assign cur_byte[1] = in_byte1;
  assign cur_byte[2] = in_byte2;
  assign cur_byte[3] = four_byte_r ? in_byte3 : '0;

  // Hold the first pixel of each pair.
  always_ff @(posedge clk) begin
    if (active && !col_cnt_r[0]) begin
      first_r <= cur_byte;
    end
  end

  // One lane per byte: pair sum now, final add in stage one.
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    bds_lane u_lane (
      .clk        (clk),
      .first_byte (first_r[k]),
      .cur_byte   (cur_byte[k]),
      .load       (rd_en),
      .stored_sum (rd_data_r[k*SUM_W +: SUM_W]),
      .pair_sum   (pair_sum[k]),
      .avg_byte   (lane_avg[k])
    );
    assign wr_data[k*SUM_W +: SUM_W] = pair_sum[k];
  end

  // Line store of packed even-row pair sums, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[slot];
    end
  end

  // Stage one holds one pending output until the output register takes it.
  always_comb begin
    s1_ctl_nxt = s1_ctl_r;
    if (rd_en) begin
      s1_ctl_nxt.vld  = 1'b1;
      s1_ctl_nxt.last = row_last && col_last;
    end else if (s1_go) begin
      s1_ctl_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  bds_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_ctl         (s1_ctl_r),
    .four_byte      (four_byte_r),
    .lane_avg       (lane_avg),
    .s1_go          (s1_go),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_avg_byte0  (out_avg_byte0),
    .out_avg_byte1  (out_avg_byte1),
    .out_avg_byte2  (out_avg_byte2),
    .out_avg_byte3  (out_avg_byte3),
    .out_last_pixel (out_last_pixel)
  );

`ifndef NO_ASSERTIONS
  // A pending output never disappears without moving to the output register.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctl_r.vld && !s1_go |=> s1_ctl_r.vld)
    else $error("stage one output dropped");

  // No pixel is taken while stage one is blocked.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s1_ctl_r.vld |-> s1_go)
    else $error("input accepted over a stalled stage one");

  // Bad geometry freezes the raster position.
  a_bad_geom_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !geom_ok && !cfg_we |=> $stable(col_cnt_r) && $stable(row_cnt_r))
    else $error("position moved under bad geometry");

  // The column stays inside the configured row.
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    geom_ok |-> ({1'b0, col_cnt_r} < src_width_r))
    else $error("column count beyond source width");

  // Store and fetch never happen together; stores come only on even rows.
  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en && !row_cnt_r[0])
    else $error("line store written on an odd row");
`endif

endmodule

/* dv/box_downsample_2x2_unit_tb.sv */
`timescale 1ns / 100ps

module box_downsample_2x2_unit_tb;
  import bds_pkg::*;

  // Index past the three geometry registers; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Odd-row pair results pass stage one and the output register; leave margin
  localparam int SETTLE_CYCLES = 6;
  // Good-geometry pixels for the random part, on top of the wide image
  localparam int unsigned RAND_PIXELS = 240;

  // One source pixel: index k holds byte k, so a hex literal reads byte3..byte0
  typedef px_byte_t [NUM_LANES-1:0] pixel_t;
  typedef logic [SUM_W-1:0] lane_sum_t;

  typedef struct packed {
    px_byte_t avg0;
    px_byte_t avg1;
    px_byte_t avg2;
    px_byte_t avg3;
    logic     last;
  } avg_px_t;

  // Where a directed row takes its expectation from
  typedef enum logic [1:0] {
    EXP_PREDICTED,
    EXP_TYPED_NONE,
    EXP_TYPED_RESULT
  } exp_src_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pixel_t                px;
    exp_src_t              src;
    avg_px_t               want;
  } dir_row_t;

  localparam avg_px_t NO_AVG = '0;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_ready;
  px_byte_t              in_byte0;
  px_byte_t              in_byte1;
  px_byte_t              in_byte2;
  px_byte_t              in_byte3;
  logic                  out_valid;
  logic                  out_ready;
  px_byte_t              out_avg_byte0;
  px_byte_t              out_avg_byte1;
  px_byte_t              out_avg_byte2;
  px_byte_t              out_avg_byte3;
  logic                  out_last_pixel;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  box_downsample_2x2_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte0       (in_byte0),
    .in_byte1       (in_byte1),
    .in_byte2       (in_byte2),
    .in_byte3       (in_byte3),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_avg_byte0  (out_avg_byte0),
    .out_avg_byte1  (out_avg_byte1),
    .out_avg_byte2  (out_avg_byte2),
    .out_avg_byte3  (out_avg_byte3),
    .out_last_pixel (out_last_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Downsampler predictor: geometry registers, pair buffer, line of pair sums
  // and the raster position, all mirrored from the block's reset state.
  // --------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  geo_width  = WIDTH_W'(2);
  logic [HEIGHT_W-1:0] geo_height = HEIGHT_W'(2);
  logic                geo_four   = 1'b0;
  pixel_t              pair_first = '0;
  lane_sum_t           line_sums [LINE_DEPTH][NUM_LANES];
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;

  avg_px_t     pending_avgs [$];
  int unsigned mismatch_cnt  = 0;
  int unsigned pixels_sent   = 0;
  int unsigned avgs_checked  = 0;
  int unsigned images_set    = 0;
  bit          in_steady     = 1'b0;
  bit          out_steady    = 1'b0;

  function automatic bit geometry_ok();
    if (geo_width < 2 || geo_width[0] || geo_width > MAX_WIDTH) return 1'b0;
    if (geo_height < 2 || geo_height[0] || geo_height > HEIGHT_LIMIT) return 1'b0;
    return 1'b1;
  endfunction

  // Mirror a register write; any real register restarts the image at the origin
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_SOURCE_WIDTH) geo_width = data[WIDTH_W-1:0];
    else if (idx == REG_SOURCE_HEIGHT) geo_height = data[HEIGHT_W-1:0];
    else if (idx == REG_FOUR_BYTE_PIXELS) geo_four = data[0];
    else return;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advance the predictor by one accepted pixel; return 1 when a block completes
  function automatic bit predict_avg_px(input pixel_t px, output avg_px_t res);
    pixel_t         b;
    pixel_t         avg;
    lane_sum_t      pair;
    logic [SUM_W:0] total;
    int unsigned    slot;
    bit             emitted;
    emitted = 1'b0;
    res     = '0;
    avg     = '0;
    if (!geometry_ok()) return 1'b0;
    b = px;
    if (!geo_four) b[3] = '0;
    slot = col_pos >> 1;
    if (!col_pos[0]) begin
      pair_first = b;
    end else begin
      for (int k = 0; k < NUM_LANES; k++) begin
        pair = lane_sum_t'(pair_first[k]) + lane_sum_t'(b[k]);
        if (!row_pos[0]) begin
          line_sums[slot][k] = pair;
        end else begin
          total  = {1'b0, line_sums[slot][k]} + {1'b0, pair};
          avg[k] = total[SUM_W:2];
        end
      end
      if (row_pos[0]) begin
        res.avg0 = avg[0];
        res.avg1 = avg[1];
        res.avg2 = avg[2];
        res.avg3 = avg[3];
        res.last = (row_pos + 1 == geo_height) && (col_pos + 1 == geo_width);
        emitted  = 1'b1;
      end
    end
    if (col_pos + 1 >= geo_width) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= geo_height) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return emitted;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] averaged pixel %0d, %s: got 0x%0h, expected 0x%0h",
             $time, avgs_checked, field, got, want);
    mismatch_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Present one pixel after a random gap, hold it until taken, then record what
  // the block owes for it. Valid stays up across back-to-back transactions.
  task automatic send_pixel(input pixel_t px, input exp_src_t src, input avg_px_t typed_want);
    int      gap;
    avg_px_t guess;
    bit      has_avg;
    gap = in_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte0 <= px[0];
    in_byte1 <= px[1];
    in_byte2 <= px[2];
    in_byte3 <= px[3];
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    has_avg = predict_avg_px(px, guess);
    case (src)
      EXP_PREDICTED:    if (has_avg) pending_avgs.push_back(guess);
      EXP_TYPED_RESULT: pending_avgs.push_back(typed_want);
      default:          ;
    endcase
  endtask

  // Drain the pipeline: drop valid, wait out every owed result, then let any
  // pixel that produces nothing clear the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while idle; the drain above always spaces two writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  // Program a full geometry; upper width and mode data bits carry noise to ignore
  task automatic set_geometry(input int unsigned w, input int unsigned h, input bit four);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[WIDTH_W-1:0] = WIDTH_W'(w);
    write_reg(REG_SOURCE_WIDTH, d);
    write_reg(REG_SOURCE_HEIGHT, CFG_DATA_W'(h));
    d = CFG_DATA_W'($urandom);
    d[0] = four;
    write_reg(REG_FOUR_BYTE_PIXELS, d);
    images_set++;
  endtask

  // Random pixel, biased toward saturated and empty ones
  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // Feed random pixels; optionally hit the spare index mid-image, which must
  // leave the raster position alone
  task automatic feed_pixels(input int unsigned npix, input bit spare_write);
    for (int unsigned i = 0; i < npix; i++) begin
      if (spare_write && i == npix / 2) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      send_pixel(rand_pixel(), EXP_PREDICTED, NO_AVG);
    end
  endtask

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic dir_row_t pix_row(pixel_t px, exp_src_t src, avg_px_t want);
    dir_row_t r;
    r      = '0;
    r.px   = px;
    r.src  = src;
    r.want = want;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls on out_ready, with steady stretches
  // --------------------------------------------------------------------------
  initial begin : out_side
    int          stall;
    int unsigned taken;
    taken = 0;
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      // Redraw the stall style every 64 transactions so long no-stall runs occur
      if (taken % 64 == 0) out_steady = ($urandom_range(0, 3) == 0);
      stall = out_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Compare each accepted output against the oldest owed result, field by field
  always @(posedge clk) begin
    avg_px_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_avgs.size() == 0) begin
        report_mismatch("unexpected transaction", out_avg_byte0, 0);
      end else begin
        want = pending_avgs.pop_front();
        if (out_avg_byte0 !== want.avg0) report_mismatch("avg_byte0", out_avg_byte0, want.avg0);
        if (out_avg_byte1 !== want.avg1) report_mismatch("avg_byte1", out_avg_byte1, want.avg1);
        if (out_avg_byte2 !== want.avg2) report_mismatch("avg_byte2", out_avg_byte2, want.avg2);
        if (out_avg_byte3 !== want.avg3) report_mismatch("avg_byte3", out_avg_byte3, want.avg3);
        if (out_last_pixel !== want.last)
          report_mismatch("last_pixel", out_last_pixel, want.last);
      end
      avgs_checked++;
    end
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t              dir_table [$];
    dir_row_t              row;
    logic [CFG_DATA_W-1:0] d;
    int unsigned           w;
    int unsigned           h;
    int unsigned           npix;
    int unsigned           pick;
    int unsigned           good_pixels;

    good_pixels = 0;
    in_valid  <= 1'b0;
    in_byte0  <= '0;
    in_byte1  <= '0;
    in_byte2  <= '0;
    in_byte3  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    // Hold reset, then release it once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Reset geometry is 2x2, three bytes per pixel.
    // Saturated image: byte3 must be ignored, averages stay at full scale.
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_RESULT,
      '{avg0: 8'hFF, avg1: 8'hFF, avg2: 8'hFF, avg3: 8'h00, last: 1'b1}));
    // Image end wraps: a black image right after, with junk in the ignored byte
    dir_table.push_back(pix_row(32'hA5000000, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hA5000000, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hA5000000, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hA5000000, EXP_TYPED_RESULT,
      '{avg0: 8'h00, avg1: 8'h00, avg2: 8'h00, avg3: 8'h00, last: 1'b1}));
    // Four-byte mode: all four lanes at full scale
    dir_table.push_back(cfg_row(REG_FOUR_BYTE_PIXELS, CFG_DATA_W'(1)));
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_RESULT,
      '{avg0: 8'hFF, avg1: 8'hFF, avg2: 8'hFF, avg3: 8'hFF, last: 1'b1}));
    // 4x2 image with remainders that truncation must drop; two outputs, one last
    dir_table.push_back(cfg_row(REG_SOURCE_WIDTH, CFG_DATA_W'(4)));
    dir_table.push_back(pix_row(32'h01020380, EXP_PREDICTED, NO_AVG));
    dir_table.push_back(pix_row(32'h7F000102, EXP_PREDICTED, NO_AVG));
    dir_table.push_back(pix_row(32'h10FE0001, EXP_PREDICTED, NO_AVG));
    dir_table.push_back(pix_row(32'hC3015AFF, EXP_PREDICTED, NO_AVG));
    dir_table.push_back(pix_row(32'h00010203, EXP_PREDICTED, NO_AVG));
    dir_table.push_back(pix_row(32'h80FF7F01, EXP_PREDICTED, NO_AVG));
    dir_table.push_back(pix_row(32'hFE01FE01, EXP_PREDICTED, NO_AVG));
    dir_table.push_back(pix_row(32'h3C3C3C3C, EXP_PREDICTED, NO_AVG));
    // Odd width: pixels still taken, nothing comes out
    dir_table.push_back(cfg_row(REG_SOURCE_WIDTH, CFG_DATA_W'(3)));
    dir_table.push_back(pix_row(32'hFFFFFFFF, EXP_TYPED_NONE, NO_AVG));
    dir_table.push_back(pix_row(32'h12345678, EXP_TYPED_NONE, NO_AVG));
    // Spare index with every data bit set: no effect
    dir_table.push_back(cfg_row(REG_SPARE, '1));

    foreach (dir_table[i]) begin
      row = dir_table[i];
      if (row.is_cfg) write_reg(row.idx, row.data);
      else send_pixel(row.px, row.src, row.want);
    end

    // Widest line at the tallest height: a full even row writes every line entry,
    // then the start of the odd row reads some of them back
    set_geometry(MAX_WIDTH, HEIGHT_LIMIT, 1'($urandom_range(0, 1)));
    feed_pixels(MAX_WIDTH + MAX_WIDTH / 4, 1'b0);

    // Random phases: mostly small images, some wider ones, some broken geometry
    while (good_pixels < RAND_PIXELS) begin
      pick      = $urandom_range(0, 99);
      in_steady = ($urandom_range(0, 4) == 0);
      if (pick < 8) begin
        // Break one dimension: odd, below 2, or past its limit
        d = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 2))
          0:       d[0] = 1'b1;
          1:       d = CFG_DATA_W'($urandom_range(0, 1));
          default: d = CFG_DATA_W'(2 * $urandom_range(HEIGHT_LIMIT / 2 + 1, 4095));
        endcase
        if ($urandom_range(0, 1)) begin
          // Width only sees its low bits; force those out of range too
          if (d[WIDTH_W-1:0] >= 2 && !d[0] && d[WIDTH_W-1:0] <= MAX_WIDTH)
            d[WIDTH_W-1:0] = WIDTH_W'(2 * $urandom_range(MAX_WIDTH / 2 + 1, 1023));
          write_reg(REG_SOURCE_WIDTH, d);
        end else begin
          write_reg(REG_SOURCE_HEIGHT, d);
        end
        feed_pixels($urandom_range(4, 12), 1'b0);
      end else begin
        w    = (pick < 20) ? 2 * $urandom_range(1, 32) : 2 * $urandom_range(1, 8);
        h    = 2 * $urandom_range(1, 4);
        npix = w * h * $urandom_range(1, 2);
        // Sometimes stop mid-image; the next register write restarts it
        if ($urandom_range(0, 5) == 0) npix = $urandom_range(1, npix - 1);
        // Keep the random part within its pixel budget
        if (npix > RAND_PIXELS - good_pixels) npix = RAND_PIXELS - good_pixels;
        set_geometry(w, h, 1'($urandom_range(0, 1)));
        feed_pixels(npix, $urandom_range(0, 9) == 0);
        good_pixels += npix;
      end
    end

    // Drain and give the pipeline time to show any stray output
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Fed %0d source pixels over %0d programmed geometries, incl. a 1024-wide image",
             pixels_sent, images_set);
    $display("Checked %0d averaged pixels; %0d field mismatches", avgs_checked, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
